/* hw/rtl/qmm_pkg.sv */
// shared types and constants for the quad motor mixer with square-root thrust mapping
package qmm_pkg;

   localparam int MotorCount = 4;
   localparam int LiftW = 16;
   localparam int CmdW = 24;
   localparam int TrimW = 8;
   localparam int MotorW = 11;
   localparam int CsrIdxW = 2;

   // thrust term fits in 29 bits signed, one spare bit kept
   localparam int TermW = 30;
   localparam int OpndW = 28;
   localparam int RootW = OpndW / 2;
   localparam int RemW = RootW + 1;
   localparam int MixW = RootW + 2;

   localparam int RootStepsPerStage = 2;

   localparam int ReqDataW = LiftW + 3 * CmdW;
   localparam int RspDataW = ((MotorCount * MotorW + 7) / 8) * 8;

   localparam int LiftCoef = 5;
   localparam int AxisCoef = 10;
   localparam int YawCoef = 8;
   localparam int LiftThresh = 10;
   localparam int MotorFloor = 200;
   localparam int MotorCeil = 1000;

   typedef logic [OpndW-1:0] opnd_type;
   typedef logic [RootW-1:0] root_type;

   typedef struct packed {
      logic lift_low;
      logic lift_high;
   } ctl_type;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_MOTOR0_TRIM = 2'd0,
      CSR_MOTOR1_TRIM = 2'd1,
      CSR_MOTOR2_TRIM = 2'd2,
      CSR_MOTOR3_TRIM = 2'd3
   } csr_idx_type;

endpackage

/* hw/rtl/qmm_root_pipe.sv */
// pipelined floor square root, four lanes, a few result bits per stage
module qmm_root_pipe
   import qmm_pkg::*;
#(
   parameter int STEPS_PER_STAGE = RootStepsPerStage
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  opnd_type in_opnd [MotorCount],
   input  ctl_type  in_ctl,
   output logic     out_valid,
   input  logic     out_ready,
   output root_type out_root [MotorCount],
   output ctl_type  out_ctl
);

   localparam int Stages = (RootW + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;

   typedef struct packed {
      logic [RemW-1:0] rem;
      root_type        root;
      opnd_type        opnd;
   } lane_type;

   // one restoring step: bring down two operand bits, try root*4+1
   function automatic lane_type root_step(input lane_type l);
      logic [RemW+1:0] cur;
      logic [RemW+1:0] trial;
      logic [RemW+1:0] diff;
      lane_type        r;
      cur = {l.rem, l.opnd[OpndW-1 -: 2]};
      trial = {{(RemW - RootW){1'b0}}, l.root, 2'b01};
      diff = cur - trial;
      r.opnd = {l.opnd[OpndW-3:0], 2'b00};
      if (cur >= trial) begin
         r.rem = diff[RemW-1:0];
         r.root = {l.root[RootW-2:0], 1'b1};
      end else begin
         r.rem = cur[RemW-1:0];
         r.root = {l.root[RootW-2:0], 1'b0};
      end
      return r;
   endfunction

   lane_type lane_ff [Stages][MotorCount];
   lane_type lane_in [Stages][MotorCount];
   ctl_type  ctl_ff [Stages];
   ctl_type  ctl_in [Stages];
   logic [Stages-1:0] valid_ff;
   logic [Stages-1:0] valid_in;
   logic [Stages:0]   ready;

   assign ready[Stages] = out_ready;

   for (genvar k = 0; k < Stages; k++) begin : g_stage
      assign ready[k] = !valid_ff[k] || ready[k+1];

      if (k == 0) begin : g_first
         always_comb begin
            lane_type cur_l;
            for (int m = 0; m < MotorCount; m++) begin
               cur_l.rem = '0;
               cur_l.root = '0;
               cur_l.opnd = in_opnd[m];
               for (int j = 0; j < STEPS_PER_STAGE; j++) begin
                  if (j < RootW) begin
                     cur_l = root_step(cur_l);
                  end
               end
               lane_in[k][m] = cur_l;
            end
            ctl_in[k] = in_ctl;
            valid_in[k] = in_valid;
         end
      end else begin : g_next
         always_comb begin
            lane_type cur_l;
            for (int m = 0; m < MotorCount; m++) begin
               cur_l = lane_ff[k-1][m];
               for (int j = 0; j < STEPS_PER_STAGE; j++) begin
                  if (k * STEPS_PER_STAGE + j < RootW) begin
                     cur_l = root_step(cur_l);
                  end
               end
               lane_in[k][m] = cur_l;
            end
            ctl_in[k] = ctl_ff[k-1];
            valid_in[k] = valid_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (ready[k]) begin
            valid_ff[k] <= valid_in[k];
         end
      end

      always_ff @(posedge clock) begin
         if (ready[k]) begin
            lane_ff[k] <= lane_in[k];
            ctl_ff[k] <= ctl_in[k];
         end
      end
   end

   assign in_ready = ready[0];
   assign out_valid = valid_ff[Stages-1];
   assign out_ctl = ctl_ff[Stages-1];

   always_comb begin
      for (int m = 0; m < MotorCount; m++) begin
         out_root[m] = lane_ff[Stages-1][m].root;
      end
   end

   // a held result must not change under a stall; checked on out_ctl and the roots of lanes 0 and 3
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      out_valid && !out_ready |=> out_valid && $stable(out_ctl)
         && $stable(lane_ff[Stages-1][0].root) && $stable(lane_ff[Stages-1][3].root))
      else $error("root pipe output changed while stalled");

   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !valid_ff[0] |-> in_ready)
      else $error("root pipe refused a beat with its first stage empty");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> valid_ff == '0)
      else $error("root pipe holds valid data after reset");

endmodule

/* hw/rtl/quad_motor_mixer_sqrt_top.sv */
// a req beat passes the mixing register, the square-root stage registers and the output register before rsp_tvalid
// throughput: one command set per cycle while rsp_tready stays high
// pipeline depth is set by the square-root stages, STEPS_PER_STAGE root bits each
// stalls back up stage by stage; empty stages keep taking beats
// reset: synchronous, clears all stage valid bits and the four trim registers to 0
module quad_motor_mixer_sqrt_top
   import qmm_pkg::*;
#(
   parameter int STEPS_PER_STAGE = RootStepsPerStage
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   // lift_cmd[15:0], roll_cmd[39:16], pitch_cmd[63:40], yaw_cmd[87:64]
   input  logic [ReqDataW-1:0] req_tdata,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   // motor0[10:0], motor1[21:11], motor2[32:22], motor3[43:33], zero fill above
   output logic [RspDataW-1:0] rsp_tdata,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [TrimW-1:0]    csr_data
);

   logic signed [TrimW-1:0] trim_ff [MotorCount];

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int m = 0; m < MotorCount; m++) begin
            trim_ff[m] <= '0;
         end
      end else if (csr_valid) begin
         case (csr_idx_type'(csr_index))
            CSR_MOTOR0_TRIM: trim_ff[0] <= csr_data;
            CSR_MOTOR1_TRIM: trim_ff[1] <= csr_data;
            CSR_MOTOR2_TRIM: trim_ff[2] <= csr_data;
            CSR_MOTOR3_TRIM: trim_ff[3] <= csr_data;
            default: ;
         endcase
      end
   end

   // mixing stage
   logic [LiftW-1:0]       lift;
   logic signed [TermW-1:0] lift_s, roll_s, pitch_s, yaw_s;
   logic signed [TermW-1:0] term [MotorCount];
   opnd_type               opnd_in [MotorCount];
   ctl_type                ctl_in;
   opnd_type               opnd_ff [MotorCount];
   ctl_type                ctl_ff;
   logic                   s1_valid_ff;
   logic                   pipe_in_ready;

   assign lift = req_tdata[LiftW-1:0];

   always_comb begin
      lift_s = TermW'($signed({1'b0, lift}));
      roll_s = TermW'($signed(req_tdata[LiftW +: CmdW]));
      pitch_s = TermW'($signed(req_tdata[LiftW + CmdW +: CmdW]));
      yaw_s = TermW'($signed(req_tdata[LiftW + 2 * CmdW +: CmdW]));
      term[0] = TermW'(LiftCoef * lift_s + AxisCoef * pitch_s - YawCoef * yaw_s);
      term[1] = TermW'(LiftCoef * lift_s - AxisCoef * roll_s + YawCoef * yaw_s);
      term[2] = TermW'(LiftCoef * lift_s - AxisCoef * pitch_s - YawCoef * yaw_s);
      term[3] = TermW'(LiftCoef * lift_s + AxisCoef * roll_s + YawCoef * yaw_s);
      for (int m = 0; m < MotorCount; m++) begin
         // negative thrust roots to zero
         opnd_in[m] = term[m][TermW-1] ? '0 : term[m][OpndW-1:0];
      end
      ctl_in.lift_low = lift < LiftW'(LiftThresh);
      ctl_in.lift_high = lift > LiftW'(LiftThresh);
   end

   assign req_tready = !s1_valid_ff || pipe_in_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready) begin
         opnd_ff <= opnd_in;
         ctl_ff <= ctl_in;
      end
   end

   // square roots
   logic     pipe_out_valid;
   logic     pipe_out_ready;
   root_type pipe_root [MotorCount];
   ctl_type  pipe_ctl;

   qmm_root_pipe #(
      .STEPS_PER_STAGE(STEPS_PER_STAGE)
   ) u_root_pipe (
      .clock    (clock),
      .reset    (reset),
      .in_valid (s1_valid_ff),
      .in_ready (pipe_in_ready),
      .in_opnd  (opnd_ff),
      .in_ctl   (ctl_ff),
      .out_valid(pipe_out_valid),
      .out_ready(pipe_out_ready),
      .out_root (pipe_root),
      .out_ctl  (pipe_ctl)
   );

   // trim and clamp into the output register
   logic signed [MixW-1:0]   mix;
   logic signed [MotorW-1:0] motor_in [MotorCount];
   logic signed [MotorW-1:0] motor_ff [MotorCount];
   logic                     rsp_valid_ff;
   logic                     out_load;

   assign pipe_out_ready = !rsp_valid_ff || rsp_tready;
   assign out_load = pipe_out_ready;

   always_comb begin
      mix = '0;
      for (int m = 0; m < MotorCount; m++) begin
         mix = $signed({2'b00, pipe_root[m]}) + MixW'(trim_ff[m]);
         if (pipe_ctl.lift_low) begin
            mix = '0;
         end
         if (pipe_ctl.lift_high && mix < MixW'(MotorFloor)) begin
            mix = MixW'(MotorFloor);
         end
         if (mix >= MixW'(MotorCeil)) begin
            mix = MixW'(MotorCeil);
         end
         motor_in[m] = mix[MotorW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= pipe_out_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         motor_ff <= motor_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {{(RspDataW - MotorCount * MotorW){1'b0}},
                       motor_ff[3], motor_ff[2], motor_ff[1], motor_ff[0]};

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |->
         motor_ff[0] <= MotorW'(MotorCeil) && motor_ff[1] <= MotorW'(MotorCeil)
         && motor_ff[2] <= MotorW'(MotorCeil) && motor_ff[3] <= MotorW'(MotorCeil))
      else $error("motor drive above ceiling");

   a_lift_low: assert property (@(posedge clock) disable iff (reset)
      out_load && pipe_out_valid && pipe_ctl.lift_low |=>
         motor_ff[0] == '0 && motor_ff[1] == '0 && motor_ff[2] == '0 && motor_ff[3] == '0)
      else $error("low lift did not force motors off");

   a_lift_high: assert property (@(posedge clock) disable iff (reset)
      out_load && pipe_out_valid && pipe_ctl.lift_high |=>
         motor_ff[0] >= MotorW'(MotorFloor) && motor_ff[1] >= MotorW'(MotorFloor)
         && motor_ff[2] >= MotorW'(MotorFloor) && motor_ff[3] >= MotorW'(MotorFloor))
      else $error("high lift left a motor below the floor");

endmodule

/* tb/quad_motor_mixer_sqrt_top_tb.sv */
// testbench for the quad motor mixer: stream driver, predictor and result checker
module quad_motor_mixer_sqrt_top_tb
   import qmm_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CycleLimit = 400000;
   localparam int DrainCycles = 12;
   localparam int RandPerPhase = 250;
   localparam int PhaseCount = 7;

   typedef logic [MotorCount-1:0][MotorW-1:0] motor_set_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [ReqDataW-1:0] req_tdata = '0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [RspDataW-1:0] rsp_tdata;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [CsrIdxW-1:0]  csr_index = '0;
   logic [TrimW-1:0]    csr_data = '0;

   logic [ReqDataW-1:0]     cmd_q[$];
   motor_set_type           motor_exp_q[$];
   logic signed [TrimW-1:0] trim_copy[MotorCount] = '{default: '0};
   bit                      gaps_on = 1'b1;
   bit                      mix_fail = 1'b0;
   int unsigned             cycle_count = 0;

   const csr_idx_type trim_reg_idx[MotorCount] = '{
      CSR_MOTOR0_TRIM, CSR_MOTOR1_TRIM, CSR_MOTOR2_TRIM, CSR_MOTOR3_TRIM
   };

   quad_motor_mixer_sqrt_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // floor square root, two bits of the operand per step
   function automatic longint floor_root(longint x);
      longint r;
      longint b;
      r = 0;
      b = longint'(1) << 30;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic motor_set_type mix_predict(logic [ReqDataW-1:0] d);
      longint lift;
      longint roll;
      longint pitch;
      longint yaw;
      longint term[MotorCount];
      longint v;
      motor_set_type r;
      lift  = longint'(d[LiftW-1:0]);
      roll  = longint'($signed(d[LiftW +: CmdW]));
      pitch = longint'($signed(d[LiftW+CmdW +: CmdW]));
      yaw   = longint'($signed(d[LiftW+2*CmdW +: CmdW]));
      term[0] = 5 * lift + 10 * pitch - 8 * yaw;
      term[1] = 5 * lift - 10 * roll + 8 * yaw;
      term[2] = 5 * lift - 10 * pitch - 8 * yaw;
      term[3] = 5 * lift + 10 * roll + 8 * yaw;
      for (int i = 0; i < MotorCount; i++) begin
         v = (term[i] < 0) ? 0 : floor_root(term[i]);
         v = v + longint'(trim_copy[i]);
         if (lift < 10) v = 0;
         if (lift > 10 && v < 200) v = 200;
         if (v >= 1000) v = 1000;
         r[i] = v[MotorW-1:0];
      end
      return r;
   endfunction

   function automatic logic [ReqDataW-1:0] pack_cmd(
      logic [LiftW-1:0] lift, logic [CmdW-1:0] roll,
      logic [CmdW-1:0] pitch, logic [CmdW-1:0] yaw);
      return {yaw, pitch, roll, lift};
   endfunction

   function automatic logic [CmdW-1:0] rand_axis();
      int unsigned mag;
      logic [CmdW-1:0] v;
      mag = 0;
      case ($urandom_range(5))
         0: mag = $urandom_range(300);
         1: mag = $urandom_range(20000);
         2: mag = $urandom_range(120000);
         3: return CmdW'($urandom);
         4: return $urandom_range(1) ? 24'h7FFFFF : 24'h800000;
         default: mag = 0;
      endcase
      v = mag[CmdW-1:0];
      return $urandom_range(1) ? -v : v;
   endfunction

   function automatic logic [LiftW-1:0] rand_lift();
      case ($urandom_range(5))
         0: return LiftW'($urandom_range(20));
         1: return LiftW'(9 + $urandom_range(2));
         2: return LiftW'($urandom);
         3: return LiftW'($urandom_range(3000));
         default: return LiftW'($urandom_range(40000, 40));
      endcase
   endfunction

   task automatic add_directed();
      cmd_q.push_back(pack_cmd(16'd0, 24'd0, 24'd0, 24'd0));
      cmd_q.push_back(pack_cmd(16'd9, 24'd1000, 24'd1000, 24'd0));
      cmd_q.push_back(pack_cmd(16'd10, 24'd0, 24'd0, 24'd0));
      cmd_q.push_back(pack_cmd(16'd11, 24'd0, 24'd0, 24'd0));
      cmd_q.push_back(pack_cmd(16'd20, 24'd0, 24'd0, 24'd0));
      // lift of ten: root plus trim only, may go negative
      cmd_q.push_back(pack_cmd(16'd10, 24'd5, 24'd5, 24'd0));
      cmd_q.push_back(pack_cmd(16'd10, 24'd0, 24'd0, 24'd100));
      cmd_q.push_back(pack_cmd(16'd10, 24'd40000, -24'sd40000, 24'd0));
      cmd_q.push_back(pack_cmd(16'hFFFF, 24'd0, 24'd0, 24'd0));
      cmd_q.push_back(pack_cmd(16'hFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h800000));
      cmd_q.push_back(pack_cmd(16'hFFFF, 24'h800000, 24'h800000, 24'h7FFFFF));
      cmd_q.push_back(pack_cmd(16'd0, 24'h800000, 24'h800000, 24'h800000));
      cmd_q.push_back(pack_cmd(16'hFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF));
      // roots right at and just under the ceiling
      cmd_q.push_back(pack_cmd(16'd12, 24'd0, 24'd99994, 24'd0));
      cmd_q.push_back(pack_cmd(16'd11, 24'd0, 24'd99797, 24'd3));
      cmd_q.push_back(pack_cmd(16'd11, -24'sd4000, 24'd0, 24'd0));
      cmd_q.push_back(pack_cmd(16'd100, 24'd4000, 24'd0, -24'sd2000));
      cmd_q.push_back(pack_cmd(16'd5000, 24'd300, -24'sd700, 24'd50));
   endtask

   task automatic add_random(int count);
      for (int i = 0; i < count; i++)
         cmd_q.push_back(pack_cmd(rand_lift(), rand_axis(), rand_axis(), rand_axis()));
   endtask

   task automatic wait_drained();
      while (cmd_q.size() != 0 || req_tvalid || motor_exp_q.size() != 0)
         @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   // valid stays high across the four writes and drops once at the end
   task automatic load_trims(logic signed [TrimW-1:0] trims[MotorCount]);
      for (int i = 0; i < MotorCount; i++) begin
         csr_valid <= 1'b1;
         csr_index <= trim_reg_idx[i];
         csr_data  <= trims[i];
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
         trim_copy[i] = trims[i];
      end
      csr_valid <= 1'b0;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            motor_exp_q.push_back(mix_predict(req_tdata));
         if (!req_tvalid || req_tready) begin
            if (cmd_q.size() != 0 && !(gaps_on && $urandom_range(99) < 22)) begin
               req_tdata  <= cmd_q.pop_front();
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : rsp_monitor
      motor_set_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (motor_exp_q.size() == 0) begin
               $error("rsp beat with no command pending");
               mix_fail = 1'b1;
            end else begin
               want = motor_exp_q.pop_front();
               for (int i = 0; i < MotorCount; i++) begin
                  if (rsp_tdata[i*MotorW +: MotorW] !== want[i]) begin
                     $error("%s: expected %0d, got %0d", $sformatf("motor%0d", i),
                            $signed(want[i]), $signed(rsp_tdata[i*MotorW +: MotorW]));
                     mix_fail = 1'b1;
                  end
               end
            end
         end
         rsp_tready <= !(gaps_on && $urandom_range(99) < 22);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("quad_motor_mixer_sqrt_top: mismatch");
         $finish;
      end
   end

   initial begin : stimulus
      logic signed [TrimW-1:0] trims[MotorCount];
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      add_directed();
      wait_drained();
      for (int p = 0; p < PhaseCount; p++) begin
         case (p)
            0: trims = '{TrimW'(-128), TrimW'(-128), TrimW'(-128), TrimW'(-128)};
            1: trims = '{TrimW'(127), TrimW'(127), TrimW'(127), TrimW'(127)};
            2: trims = '{TrimW'(-128), TrimW'(127), TrimW'(-1), TrimW'(1)};
            3: trims = '{TrimW'(0), TrimW'(0), TrimW'(0), TrimW'(0)};
            default: begin
               for (int i = 0; i < MotorCount; i++) trims[i] = TrimW'($urandom);
            end
         endcase
         load_trims(trims);
         // one whole phase with both sides running flat out
         gaps_on = (p != 1);
         if (p == 0) add_directed();
         add_random(RandPerPhase);
         wait_drained();
      end
      if (!mix_fail) begin
         $display("quad_motor_mixer_sqrt_top: match");
      end else begin
         $display("quad_motor_mixer_sqrt_top: mismatch");
      end
      $finish;
   end

endmodule

/* quad_motor_mixer_sqrt_top.f */
hw/rtl/qmm_pkg.sv
hw/rtl/qmm_root_pipe.sv
hw/rtl/quad_motor_mixer_sqrt_top.sv
tb/quad_motor_mixer_sqrt_top_tb.sv
